>>> sv/lsa_pkg.sv
`timescale 1ns / 1ps

package lsa_pkg;

    // Controller states
    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_REM,
        S_RD,
        S_EX
    } t_state;

    // Operation codes carried by an item
    typedef enum logic [2:0] {
        KIND_PROBE  = 3'd0,
        KIND_READ   = 3'd1,
        KIND_WRITE  = 3'd2,
        KIND_EVICT  = 3'd3,
        KIND_INSERT = 3'd4
    } t_kind;

    typedef struct packed {
        logic load;       // capture the incoming item
        logic rd_en;      // read one set row
        logic rd_sel_in;  // read address straight from the incoming item
        logic rem_step;   // one step of the set-index remainder
        logic clr_wr;     // write a cleared row during the reset sweep
        logic exec;       // update the set row and load the result register
    } t_cmd;

    typedef struct packed {
        logic idx_direct; // set index is a plain bit field of the block number
        logic rem_last;   // last remainder step this cycle
        logic clr_last;   // last row of the clearing sweep this cycle
        logic out_busy;   // result register full and not taken this cycle
    } t_stat;

endpackage

>>> sv/lsa_ctrl.sv
`timescale 1ns / 1ps

module lsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  lsa_pkg::t_stat i_stat,
    output lsa_pkg::t_cmd  o_cmd
);

    lsa_pkg::t_state r_state;
    lsa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsa_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lsa_pkg::S_CLR: begin
                if (i_stat.clr_last) begin
                    n_state = lsa_pkg::S_IDLE;
                end
            end
            lsa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.idx_direct ? lsa_pkg::S_EX : lsa_pkg::S_REM;
                end
            end
            lsa_pkg::S_REM: begin
                if (i_stat.rem_last) begin
                    n_state = lsa_pkg::S_RD;
                end
            end
            lsa_pkg::S_RD: begin
                n_state = lsa_pkg::S_EX;
            end
            lsa_pkg::S_EX: begin
                if (!i_stat.out_busy) begin
                    n_state = lsa_pkg::S_IDLE;
                end
            end
            default: n_state = lsa_pkg::S_CLR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lsa_pkg::S_CLR: begin
                o_cmd.clr_wr = 1'b1;
            end
            lsa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // power-of-two sets: index is known now, read the row at once
                    if (i_stat.idx_direct) begin
                        o_cmd.rd_en     = 1'b1;
                        o_cmd.rd_sel_in = 1'b1;
                    end
                end
            end
            lsa_pkg::S_REM: begin
                o_cmd.rem_step = 1'b1;
            end
            lsa_pkg::S_RD: begin
                o_cmd.rd_en = 1'b1;
            end
            lsa_pkg::S_EX: begin
                o_cmd.exec = !i_stat.out_busy;
            end
            default: ;
        endcase
    end

endmodule

>>> sv/lsa_dp.sv
`timescale 1ns / 1ps

module lsa_dp #(
    parameter int NUM_SETS          = 64,
    parameter int WAYS              = 4,
    parameter int BLOCK_NUMBER_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lsa_pkg::t_cmd  i_cmd,
    output lsa_pkg::t_stat o_stat,
    input  logic [2:0]     i_kind,
    input  logic [31:0]    i_block_number,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic           o_present,
    output logic           o_evicted,
    output logic [31:0]    o_evicted_block,
    output logic           o_evicted_dirty,
    output logic           o_error
);

    localparam int TAG_W      = (BLOCK_NUMBER_BITS < 32) ? BLOCK_NUMBER_BITS : 32;
    localparam int IDX_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int AGE_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int REM_STEPS  = 2;
    localparam int CNT_W      = 1;
    localparam int RECIP_SH   = TAG_W + IDX_W;
    localparam int PROD_W     = 2 * TAG_W + 1;
    localparam bit IDX_DIRECT = (NUM_SETS & (NUM_SETS - 1)) == 0;
    localparam int AGE_LO     = WAYS * TAG_W;
    localparam int DIRTY_LO   = AGE_LO + WAYS * AGE_W;
    localparam int VALID_LO   = DIRTY_LO + WAYS;
    localparam int ROW_W      = VALID_LO + WAYS;
    localparam logic [AGE_W-1:0] AGE_OLDEST = AGE_W'(WAYS - 1);
    // ceil(2^RECIP_SH / NUM_SETS): exact quotient for every TAG_W-bit block number
    localparam logic [TAG_W:0] RECIP =
        (TAG_W + 1)'(((64'd1 << RECIP_SH) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));

    logic [TAG_W-1:0]  in_blk;
    logic [IDX_W-1:0]  in_idx;
    logic [2:0]        r_kind;
    logic [TAG_W-1:0]  r_blk;
    logic [IDX_W-1:0]  r_idx;
    logic [PROD_W-1:0] quo_prod;
    logic [TAG_W-1:0]  r_quo;
    logic [TAG_W-1:0]  rem_full;
    logic [CNT_W-1:0]  r_rem_cnt;
    logic [IDX_W-1:0]  r_clr_cnt;

    logic [ROW_W-1:0] mem [NUM_SETS];
    logic [ROW_W-1:0] r_rd_row;
    logic [ROW_W-1:0] exec_row;
    logic [ROW_W-1:0] wr_row;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;

    logic [WAYS-1:0]  rd_valid;
    logic [WAYS-1:0]  rd_dirty;
    logic [TAG_W-1:0] rd_tag [WAYS];
    logic [AGE_W-1:0] rd_age [WAYS];

    logic [WAYS-1:0]  hit_vec;
    logic [WAYS-1:0]  vic_vec;
    logic [WAYS-1:0]  slot_vec;
    logic             hit_any;
    logic             full;
    logic [AGE_W-1:0] hit_age;
    logic [TAG_W-1:0] vic_tag;
    logic             vic_dirty;

    logic [WAYS-1:0]  new_valid;
    logic [WAYS-1:0]  new_dirty;
    logic [TAG_W-1:0] new_tag [WAYS];
    logic [AGE_W-1:0] new_age [WAYS];

    logic             n_present;
    logic             n_evicted;
    logic [TAG_W-1:0] n_evicted_block;
    logic             n_evicted_dirty;
    logic             n_error;

    logic             r_out_valid;
    logic             r_present;
    logic             r_evicted;
    logic [TAG_W-1:0] r_evicted_block;
    logic             r_evicted_dirty;
    logic             r_error;

    assign in_blk = TAG_W'(i_block_number);
    assign in_idx = IDX_DIRECT ? IDX_W'(in_blk & TAG_W'(NUM_SETS - 1)) : '0;

    // Set index = block - q * NUM_SETS; q by reciprocal multiplication in the
    // first step, the multiply-subtract in the second
    assign quo_prod = PROD_W'(r_blk) * PROD_W'(RECIP);
    assign rem_full = r_blk - TAG_W'(r_quo * NUM_SETS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_blk  <= in_blk;
            r_idx  <= in_idx;
        end else if (i_cmd.rem_step) begin
            if (r_rem_cnt == '0) begin
                r_quo <= TAG_W'(quo_prod >> RECIP_SH);
            end else begin
                r_idx <= IDX_W'(rem_full);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem_cnt <= '0;
            r_clr_cnt <= '0;
        end else begin
            if (i_cmd.load) begin
                r_rem_cnt <= '0;
            end else if (i_cmd.rem_step) begin
                r_rem_cnt <= r_rem_cnt + 1'b1;
            end
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    // Set memory: one row holds every way of a set
    assign rd_addr = i_cmd.rd_sel_in ? in_idx : r_idx;
    assign wr_addr = i_cmd.clr_wr ? r_clr_cnt : r_idx;
    assign wr_en   = i_cmd.clr_wr | i_cmd.exec;
    assign wr_row  = i_cmd.clr_wr ? '0 : exec_row;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_row <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_row;
        end
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            rd_tag[w]   = r_rd_row[w*TAG_W +: TAG_W];
            rd_age[w]   = r_rd_row[AGE_LO + w*AGE_W +: AGE_W];
            rd_dirty[w] = r_rd_row[DIRTY_LO + w];
            rd_valid[w] = r_rd_row[VALID_LO + w];
        end
    end

    // Tags of valid ways are distinct and a full set holds every rank once,
    // so hit and victim vectors are one-hot and can be OR-merged.
    always_comb begin
        hit_age   = '0;
        vic_tag   = '0;
        vic_dirty = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = rd_valid[w] && (rd_tag[w] == r_blk);
            vic_vec[w] = rd_valid[w] && (rd_age[w] == AGE_OLDEST);
            if (hit_vec[w]) begin
                hit_age = hit_age | rd_age[w];
            end
            if (vic_vec[w]) begin
                vic_tag   = vic_tag | rd_tag[w];
                vic_dirty = vic_dirty | rd_dirty[w];
            end
        end
    end

    assign hit_any  = |hit_vec;
    assign full     = &rd_valid;
    // lowest free way
    assign slot_vec = ~rd_valid & (rd_valid + WAYS'(1));

    always_comb begin
        new_valid       = rd_valid;
        new_dirty       = rd_dirty;
        new_tag         = rd_tag;
        new_age         = rd_age;
        n_present       = 1'b0;
        n_evicted       = 1'b0;
        n_evicted_block = '0;
        n_evicted_dirty = 1'b0;
        n_error         = 1'b0;
        unique case (r_kind) inside
            lsa_pkg::KIND_PROBE: begin
                n_present = hit_any;
            end
            lsa_pkg::KIND_READ, lsa_pkg::KIND_WRITE: begin
                n_present = hit_any;
                for (int w = 0; w < WAYS; w++) begin
                    if (hit_any) begin
                        if (hit_vec[w]) begin
                            new_age[w] = '0;
                            if (r_kind == lsa_pkg::KIND_WRITE) begin
                                new_dirty[w] = 1'b1;
                            end
                        end else if (rd_valid[w] && rd_age[w] < hit_age) begin
                            new_age[w] = rd_age[w] + 1'b1;
                        end
                    end
                end
            end
            lsa_pkg::KIND_EVICT: begin
                if (full) begin
                    n_evicted       = 1'b1;
                    n_evicted_block = vic_tag;
                    n_evicted_dirty = vic_dirty;
                    new_valid       = rd_valid & ~vic_vec;
                end
            end
            lsa_pkg::KIND_INSERT: begin
                n_error = hit_any | full;
                if (!(hit_any | full)) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (slot_vec[w]) begin
                            new_valid[w] = 1'b1;
                            new_tag[w]   = r_blk;
                            new_dirty[w] = 1'b0;
                            new_age[w]   = '0;
                        end else if (rd_valid[w]) begin
                            new_age[w] = rd_age[w] + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            exec_row[w*TAG_W +: TAG_W]          = new_tag[w];
            exec_row[AGE_LO + w*AGE_W +: AGE_W] = new_age[w];
            exec_row[DIRTY_LO + w]              = new_dirty[w];
            exec_row[VALID_LO + w]              = new_valid[w];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_present       <= n_present;
            r_evicted       <= n_evicted;
            r_evicted_block <= n_evicted_block;
            r_evicted_dirty <= n_evicted_dirty;
            r_error         <= n_error;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_present       = r_present;
    assign o_evicted       = r_evicted;
    assign o_evicted_block = 32'(r_evicted_block);
    assign o_evicted_dirty = r_evicted_dirty;
    assign o_error         = r_error;

    assign o_stat.idx_direct = IDX_DIRECT;
    assign o_stat.rem_last   = (r_rem_cnt == CNT_W'(REM_STEPS - 1));
    assign o_stat.clr_last   = (r_clr_cnt == IDX_W'(NUM_SETS - 1));
    assign o_stat.out_busy   = r_out_valid & ~i_out_ready;

endmodule

>>> sv/lru_set_assoc_tag_store.sv
`timescale 1ns / 1ps

// Tag store of a set-associative cache with true LRU replacement and dirty bits.
// Each item carries an operation (probe, read, write, evict, insert) and a block
// number; the set is block_number mod NUM_SETS and every item yields exactly one
// result. All ways of a set live in one memory row, so an item is a single
// read-modify-write of that row: when NUM_SETS is a power of two, a row read, then
// compare, update and write-back; otherwise the set index is first worked out
// (quotient by reciprocal multiplication, then remainder by multiply-subtract) before
// the row read. The result sits in an output register, so the next item is taken
// while it waits; the store only holds off its update while that register is still
// full. After reset a clearing sweep writes every set row once, with in_ready low.
module lru_set_assoc_tag_store #(
    parameter int NUM_SETS          = 64,
    parameter int WAYS              = 4,
    parameter int BLOCK_NUMBER_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_block_number,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_present,
    output logic        o_evicted,
    output logic [31:0] o_evicted_block,
    output logic        o_evicted_dirty,
    output logic        o_error
);

    lsa_pkg::t_cmd  cmd;
    lsa_pkg::t_stat stat;

    lsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lsa_dp #(
        .NUM_SETS          (NUM_SETS),
        .WAYS              (WAYS),
        .BLOCK_NUMBER_BITS (BLOCK_NUMBER_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_kind          (i_kind),
        .i_block_number  (i_block_number),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_present       (o_present),
        .o_evicted       (o_evicted),
        .o_evicted_block (o_evicted_block),
        .o_evicted_dirty (o_evicted_dirty),
        .o_error         (o_error)
    );

endmodule

>>> tb/tag_store_checker.sv
`timescale 1ns / 1ps

module tag_store_checker #(
    parameter int NUM_SETS = 64,
    parameter int WAYS     = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_kind,
    input  logic [31:0] i_block_number,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_present,
    input  logic        i_evicted,
    input  logic [31:0] i_evicted_block,
    input  logic        i_evicted_dirty,
    input  logic        i_error,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_hits,
    output int          o_evictions,
    output int          o_refused
);

    localparam int ENTRIES = NUM_SETS * WAYS;

    typedef struct packed {
        logic        present;
        logic        evicted;
        logic [31:0] evicted_block;
        logic        evicted_dirty;
        logic        error;
    } t_outcome;

    // Shadow copy of the tag store, way w of set s at s * WAYS + w
    logic        line_valid [ENTRIES];
    logic [31:0] line_block [ENTRIES];
    logic        line_dirty [ENTRIES];
    int          line_rank  [ENTRIES];

    t_outcome outcome_q [$];
    int fails;
    int checked;
    int hits;
    int evictions;
    int refused;

    // Applies one item to the shadow store and returns the result it must produce
    function automatic t_outcome lookup_and_update(input logic [2:0] op,
                                                   input logic [31:0] blk);
        t_outcome r;
        int base;
        int hit;
        int nvalid;
        int victim;
        int best;
        int slot;
        int old;
        r      = '0;
        base   = int'(blk % NUM_SETS) * WAYS;
        hit    = -1;
        nvalid = 0;
        for (int w = 0; w < WAYS; w++) begin
            if (line_valid[base + w]) begin
                nvalid++;
                if (hit < 0 && line_block[base + w] == blk)
                    hit = w;
            end
        end
        case (op) inside
            lsa_pkg::KIND_PROBE, lsa_pkg::KIND_READ, lsa_pkg::KIND_WRITE: begin
                r.present = (hit >= 0);
                if (hit >= 0) begin
                    hits++;
                    if (op != lsa_pkg::KIND_PROBE) begin
                        // move to most recent, everything younger ages by one
                        old = line_rank[base + hit];
                        for (int w = 0; w < WAYS; w++)
                            if (line_valid[base + w] && line_rank[base + w] < old)
                                line_rank[base + w]++;
                        line_rank[base + hit] = 0;
                        if (op == lsa_pkg::KIND_WRITE)
                            line_dirty[base + hit] = 1'b1;
                    end
                end
            end
            lsa_pkg::KIND_EVICT: begin
                if (nvalid == WAYS) begin
                    victim = 0;
                    best   = -1;
                    for (int w = 0; w < WAYS; w++)
                        if (line_valid[base + w] && line_rank[base + w] > best) begin
                            best   = line_rank[base + w];
                            victim = w;
                        end
                    r.evicted       = 1'b1;
                    r.evicted_block = line_block[base + victim];
                    r.evicted_dirty = line_dirty[base + victim];
                    for (int w = 0; w < WAYS; w++)
                        if (line_valid[base + w] && line_rank[base + w] > best)
                            line_rank[base + w]--;
                    line_valid[base + victim] = 1'b0;
                    evictions++;
                end
            end
            lsa_pkg::KIND_INSERT: begin
                if (hit >= 0 || nvalid == WAYS) begin
                    r.error = 1'b1;
                    refused++;
                end else begin
                    slot = -1;
                    for (int w = 0; w < WAYS; w++) begin
                        if (line_valid[base + w])
                            line_rank[base + w]++;
                        else if (slot < 0)
                            slot = w;
                    end
                    line_valid[base + slot] = 1'b1;
                    line_block[base + slot] = blk;
                    line_dirty[base + slot] = 1'b0;
                    line_rank[base + slot]  = 0;
                end
            end
            default: ;  // spare codes: no change, all zero
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                line_valid[i] = 1'b0;
                line_rank[i]  = 0;
            end
            outcome_q.delete();
            fails     = 0;
            checked   = 0;
            hits      = 0;
            evictions = 0;
            refused   = 0;
        end else begin
            // result side first: it always belongs to an earlier item
            if (i_out_valid && i_out_ready) begin
                got = {i_present, i_evicted, i_evicted_block, i_evicted_dirty, i_error};
                if (outcome_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display({"[%0t] result with nothing outstanding: ",
                                  "p=%b e=%b blk=%h d=%b err=%b"},
                                 $realtime, got.present, got.evicted, got.evicted_block,
                                 got.evicted_dirty, got.error);
                end else begin
                    want = outcome_q.pop_front();
                    checked++;
                    if (got !== want) begin
                        fails++;
                        if (fails <= 10)
                            $display({"[%0t] result %0d differs: expected p=%b e=%b blk=%h d=%b ",
                                      "err=%b, got p=%b e=%b blk=%h d=%b err=%b"},
                                     $realtime, checked, want.present, want.evicted,
                                     want.evicted_block, want.evicted_dirty, want.error,
                                     got.present, got.evicted, got.evicted_block,
                                     got.evicted_dirty, got.error);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                outcome_q.push_back(lookup_and_update(i_kind, i_block_number));
        end
        o_fail_count <= fails;
        o_pending    <= outcome_q.size();
        o_checked    <= checked;
        o_hits       <= hits;
        o_evictions  <= evictions;
        o_refused    <= refused;
    end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_SETS    = 64;
    localparam int WAYS        = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 400000;
    localparam int POOL_SETS   = 6;
    localparam int POOL_TAGS   = 6;
    localparam int POOL_SIZE   = POOL_SETS * POOL_TAGS;
    localparam int PHASE_ITEMS = 100;

    // codes past the last operation; the store must ignore them
    localparam logic [2:0] KIND_SPARE_5 = 3'd5;
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        in_valid     = 1'b0;
    logic [2:0]  kind         = '0;
    logic [31:0] block_number = '0;
    logic        out_ready    = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic        present;
    logic        evicted;
    logic [31:0] evicted_block;
    logic        evicted_dirty;
    logic        error_flag;

    int   gap_pct   = 0;
    int   stall_pct = 0;
    logic hold_req  = 1'b0;
    int   hold_cnt  = 0;
    int   cycles    = 0;
    int   sent      = 0;

    int fail_count;
    int pending;
    int checked;
    int hits;
    int evictions;
    int refused;

    logic [31:0] block_pool [POOL_SIZE];

    lru_set_assoc_tag_store #(
        .NUM_SETS          (NUM_SETS),
        .WAYS              (WAYS),
        .BLOCK_NUMBER_BITS (32)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_kind          (kind),
        .i_block_number  (block_number),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_present       (present),
        .o_evicted       (evicted),
        .o_evicted_block (evicted_block),
        .o_evicted_dirty (evicted_dirty),
        .o_error         (error_flag)
    );

    tag_store_checker #(
        .NUM_SETS (NUM_SETS),
        .WAYS     (WAYS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_kind          (kind),
        .i_block_number  (block_number),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_present       (present),
        .i_evicted       (evicted),
        .i_evicted_block (evicted_block),
        .i_evicted_dirty (evicted_dirty),
        .i_error         (error_flag),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_hits          (hits),
        .o_evictions     (evictions),
        .o_refused       (refused)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req)
            hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
        if (hold_req || hold_cnt > 1)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Called right after a rising edge; returns at the edge that took the item
    task automatic send_item(input logic [2:0] op, input logic [31:0] blk);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid     <= 1'b1;
        kind         <= op;
        block_number <= blk;
        do @(posedge i_clk); while (!in_ready);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic logic [2:0] pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return KIND_SPARE_5 + 3'($urandom_range(2));
        else if (r < 18)
            return lsa_pkg::KIND_PROBE;
        else if (r < 36)
            return lsa_pkg::KIND_READ;
        else if (r < 56)
            return lsa_pkg::KIND_WRITE;
        else if (r < 76)
            return lsa_pkg::KIND_EVICT;
        return lsa_pkg::KIND_INSERT;
    endfunction

    // Mostly a small pool crowded into a few sets so sets fill, age and spill
    function automatic logic [31:0] pick_block();
        if ($urandom_range(99) < 85)
            return block_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom();
    endfunction

    task automatic run_phase(input int gap, input int stall, input logic pressure);
        int useful;
        logic [2:0] op;
        in_valid  <= 1'b0;
        gap_pct   <= gap;
        stall_pct <= stall;
        hold_req  <= pressure;
        @(posedge i_clk);
        hold_req <= 1'b0;
        useful = 0;
        while (useful < PHASE_ITEMS) begin
            op = pick_kind();
            send_item(op, pick_block());
            if (op <= lsa_pkg::KIND_INSERT)
                useful++;
        end
        drain();
    endtask

    initial begin : stimulus
        int set_idx;
        for (int s = 0; s < POOL_SETS; s++) begin
            set_idx = $urandom_range(NUM_SETS - 1);
            for (int t = 0; t < POOL_TAGS; t++)
                block_pool[s * POOL_TAGS + t] = ($urandom() / NUM_SETS) * NUM_SETS + set_idx;
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // set 0 filled, hit, refused, evicted; set 63 at the top of the range
        send_item(lsa_pkg::KIND_PROBE,  32'h0000_0000);
        send_item(lsa_pkg::KIND_INSERT, 32'h0000_0000);
        send_item(lsa_pkg::KIND_INSERT, 32'h0000_0040);
        send_item(lsa_pkg::KIND_INSERT, 32'h0000_0080);
        send_item(lsa_pkg::KIND_INSERT, 32'hFFFF_FFC0);
        send_item(lsa_pkg::KIND_INSERT, 32'h0000_00C0);  // set full
        send_item(lsa_pkg::KIND_INSERT, 32'h0000_0040);  // already present
        send_item(lsa_pkg::KIND_READ,   32'h0000_0000);
        send_item(lsa_pkg::KIND_WRITE,  32'h0000_0040);
        send_item(lsa_pkg::KIND_READ,   32'h0000_0100);  // miss
        send_item(lsa_pkg::KIND_WRITE,  32'h0000_0140);  // miss
        send_item(lsa_pkg::KIND_PROBE,  32'h0000_0080);
        send_item(lsa_pkg::KIND_EVICT,  32'h0000_0000);
        send_item(lsa_pkg::KIND_EVICT,  32'h0000_0040);  // free way, nothing removed
        send_item(lsa_pkg::KIND_INSERT, 32'hFFFF_FFFF);
        send_item(lsa_pkg::KIND_INSERT, 32'hFFFF_FFFF);  // duplicate, set not full
        send_item(lsa_pkg::KIND_WRITE,  32'hFFFF_FFFF);
        send_item(KIND_SPARE_5, 32'hFFFF_FFFF);
        send_item(KIND_SPARE_6, 32'h0000_0000);
        send_item(KIND_SPARE_7, 32'hFFFF_FFC0);
        send_item(lsa_pkg::KIND_INSERT, 32'h0000_0080);
        send_item(lsa_pkg::KIND_WRITE,  32'hFFFF_FFC0);
        send_item(lsa_pkg::KIND_WRITE,  32'h0000_0000);
        send_item(lsa_pkg::KIND_EVICT,  32'h0000_0000);  // dirty victim
        drain();

        run_phase(0, 0, 1'b1);
        run_phase(75, 0, 1'b0);
        run_phase(0, 75, 1'b0);
        run_phase(24, 24, 1'b0);

        stall_pct <= 0;
        repeat (20) @(posedge i_clk);

        $display("run: %0d items over four idle/stall mixes plus a %0d-cycle output hold-off",
                 sent, HOLD_CYCLES);
        $display("     %0d results compared: %0d hits, %0d evictions, %0d refused inserts",
                 checked, hits, evictions, refused);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
